[design/mppo_pkg.sv]
`default_nettype none
package mppo_pkg;

  localparam int RAW_W       = 12;
  localparam int GAIN_W      = 14;
  localparam int OFFS_W      = 22;
  localparam int DUTY_W      = 16;
  localparam int SUM_W       = 30;
  localparam int POWER_W     = 60;
  localparam int CFG_DATA_W  = 22;
  localparam int CFG_INDEX_W = 3;

  localparam int TICKS_PER_SAMPLE   = 2;
  localparam int TICKS_PER_DECISION = 20;

  localparam int SCNT_W = (TICKS_PER_SAMPLE > 1) ? $clog2(TICKS_PER_SAMPLE) : 1;
  localparam int DCNT_W = $clog2(TICKS_PER_DECISION);

  localparam int SCALED_W  = RAW_W + GAIN_W + 1;
  localparam int BIT_CNT_W = $clog2(SUM_W);

  localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST   = GAIN_W'(1235);
  localparam logic [OFFS_W-1:0] VOLTAGE_OFFSET_RST = OFFS_W'(99614);
  localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST   = GAIN_W'(310);
  localparam logic [OFFS_W-1:0] CURRENT_OFFSET_RST = OFFS_W'(15729);
  localparam logic [DUTY_W-1:0] DUTY_INITIAL_RST   = DUTY_W'(32768);
  localparam logic [DUTY_W-1:0] DUTY_STEP_RST      = DUTY_W'(1638);
  localparam logic [DUTY_W-1:0] DUTY_MIN_RST       = DUTY_W'(0);
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST       = DUTY_W'(65535);

  localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_GAIN   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_OFFSET = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_GAIN   = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_OFFSET = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_INITIAL   = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_STEP      = CFG_INDEX_W'(5);
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MIN       = CFG_INDEX_W'(6);
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MAX       = CFG_INDEX_W'(7);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ACCUM,
    ST_PLOAD,
    ST_MULT,
    ST_DECIDE,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [RAW_W-1:0] voltage_raw;
    logic [RAW_W-1:0] current_raw;
  } mppo_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_compare;
    logic               direction;
    logic               decided;
    logic [POWER_W-1:0] power_sum;
  } mppo_out_t;

endpackage
`default_nettype wire

[design/mppt_perturb_observe_unit.sv]
// Perturb-and-observe maximum power point tracker.
// The input channel (in_valid, in_ready, in_data) takes one word per timer tick holding
// the raw voltage and current samples. Every tick gives exactly one result word on the
// output channel (out_valid, out_ready, out_data): duty value, direction, a flag for
// ticks on which a decision was made, and the power of the latest decision.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready
// and should be written only while no tick is in flight; writing duty_initial presets
// the duty value at once.
// A plain tick goes straight to the output register; a sample tick first scales the
// samples bit-serially, one bit of the sample per cycle, and a decision tick then runs
// a bit-serial power multiply.
// One tick is handled at a time, so the next word is accepted only once the previous
// tick's result word has been loaded into the output register.
// The output register holds its word while the receiver stalls; a new word can be
// accepted meanwhile, and its result waits until the register is free.
// A synchronous reset restores the register defaults, clears the sums, tick counters and
// saved power, sets the direction to decrease and the duty value to its default.
`default_nettype none
module mppt_perturb_observe_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire mppo_pkg::mppo_in_t             in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      mppo_pkg::mppo_out_t            out_data,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [mppo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mppo_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mppo_pkg::*;

  state_t state, state_next;

  logic [GAIN_W-1:0] voltage_gain, current_gain;
  logic [OFFS_W-1:0] voltage_offset, current_offset;
  logic [DUTY_W-1:0] duty_step, duty_min, duty_max;

  logic [SCNT_W-1:0]    sample_cnt;
  logic [DCNT_W-1:0]    decision_cnt;
  logic                 do_sample, do_decide;
  logic [RAW_W-1:0]     vraw_sr, craw_sr;
  logic [SCALED_W-1:0]  vgain_sh, cgain_sh;
  logic [SCALED_W-1:0]  vacc, cacc;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [SUM_W-1:0]     voltage_sum, current_sum;
  logic [POWER_W-1:0]   prod;
  logic [POWER_W-1:0]   last_power;
  logic                 direction;
  logic                 move_en;
  logic [DUTY_W-1:0]    duty;

  logic                 in_accept;
  logic                 out_load;
  logic                 sample_hit, decision_hit;
  logic [SUM_W:0]       vtot, ctot;
  logic [SUM_W:0]       part_sum;
  logic [DUTY_W:0]      duty_up;
  logic [DUTY_W-1:0]    duty_down;
  logic [DUTY_W-1:0]    duty_new;

  assign cfg_ready    = 1'b1;
  assign in_accept    = in_valid && in_ready;
  assign sample_hit   = (sample_cnt == SCNT_W'(TICKS_PER_SAMPLE - 1));
  assign decision_hit = (decision_cnt == DCNT_W'(TICKS_PER_DECISION - 1));

  assign vtot = {1'b0, voltage_sum} + (SUM_W + 1)'(vacc);
  assign ctot = {1'b0, current_sum} + (SUM_W + 1)'(cacc);

  assign part_sum = {1'b0, prod[POWER_W-1:SUM_W]} +
                    (prod[0] ? {1'b0, current_sum} : '0);

  assign duty_up   = {1'b0, duty} + {1'b0, duty_step};
  assign duty_down = (duty > duty_step) ? duty - duty_step : '0;

  always_comb begin
    if (direction) begin
      duty_new = (duty_up > {1'b0, duty_max}) ? duty_max : duty_up[DUTY_W-1:0];
    end else begin
      duty_new = (duty_down < duty_min) ? duty_min : duty_down;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (sample_hit) begin
            state_next = ST_SCALE;
          end else if (decision_hit) begin
            state_next = ST_PLOAD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCALE: begin
        if (bit_cnt == BIT_CNT_W'(RAW_W - 1)) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_next = do_decide ? ST_PLOAD : ST_DONE;
      end
      ST_PLOAD: begin
        state_next = ST_MULT;
      end
      ST_MULT: begin
        if (bit_cnt == BIT_CNT_W'(SUM_W - 1)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_MOVE;
      end
      ST_MOVE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.duty_compare <= duty;
      out_data.direction    <= direction;
      out_data.decided      <= do_decide;
      out_data.power_sum    <= last_power;
    end
  end

  // Tick counters and the sample and decision flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_cnt   <= '0;
      decision_cnt <= '0;
      do_sample    <= 1'b0;
      do_decide    <= 1'b0;
    end else if (in_accept) begin
      do_sample    <= sample_hit;
      do_decide    <= decision_hit;
      sample_cnt   <= sample_hit ? '0 : sample_cnt + 1'b1;
      decision_cnt <= decision_hit ? '0 : decision_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      vraw_sr  <= in_data.voltage_raw;
      craw_sr  <= in_data.current_raw;
      vgain_sh <= SCALED_W'(voltage_gain);
      cgain_sh <= SCALED_W'(current_gain);
      vacc     <= SCALED_W'(voltage_offset);
      cacc     <= SCALED_W'(current_offset);
    end else if (state == ST_SCALE) begin
      vacc     <= vacc + (vraw_sr[0] ? vgain_sh : '0);
      cacc     <= cacc + (craw_sr[0] ? cgain_sh : '0);
      vgain_sh <= vgain_sh << 1;
      cgain_sh <= cgain_sh << 1;
      vraw_sr  <= vraw_sr >> 1;
      craw_sr  <= craw_sr >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept || state == ST_PLOAD) begin
      bit_cnt <= '0;
    end else if (state == ST_SCALE || state == ST_MULT) begin
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  // Shift-and-add multiply: the voltage sum is shifted out of the low half one bit
  // per cycle while partial sums of the current sum build up in the high half.
  always_ff @(posedge clk) begin
    if (state == ST_PLOAD) begin
      prod <= {{(POWER_W - SUM_W){1'b0}}, voltage_sum};
    end else if (state == ST_MULT) begin
      prod <= {part_sum, prod[SUM_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_sum <= '0;
      current_sum <= '0;
      last_power  <= '0;
      direction   <= 1'b0;
      move_en     <= 1'b0;
      duty        <= DUTY_INITIAL_RST;
    end else begin
      if (state == ST_ACCUM && do_sample) begin
        voltage_sum <= vtot[SUM_W] ? '1 : vtot[SUM_W-1:0];
        current_sum <= ctot[SUM_W] ? '1 : ctot[SUM_W-1:0];
      end
      if (state == ST_DECIDE) begin
        if (prod < last_power) begin
          direction <= ~direction;
          move_en   <= 1'b1;
        end else begin
          move_en   <= (prod != last_power);
        end
        last_power  <= prod;
        voltage_sum <= '0;
        current_sum <= '0;
      end
      if (state == ST_MOVE && move_en) begin
        duty <= duty_new;
      end
      if (cfg_valid && cfg_ready && cfg_index == REG_DUTY_INITIAL) begin
        duty <= cfg_data[DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_gain   <= VOLTAGE_GAIN_RST;
      voltage_offset <= VOLTAGE_OFFSET_RST;
      current_gain   <= CURRENT_GAIN_RST;
      current_offset <= CURRENT_OFFSET_RST;
      duty_step      <= DUTY_STEP_RST;
      duty_min       <= DUTY_MIN_RST;
      duty_max       <= DUTY_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VOLTAGE_GAIN:   voltage_gain   <= cfg_data[GAIN_W-1:0];
        REG_VOLTAGE_OFFSET: voltage_offset <= cfg_data[OFFS_W-1:0];
        REG_CURRENT_GAIN:   current_gain   <= cfg_data[GAIN_W-1:0];
        REG_CURRENT_OFFSET: current_offset <= cfg_data[OFFS_W-1:0];
        REG_DUTY_INITIAL: begin
          // The preset goes straight into the duty register.
        end
        REG_DUTY_STEP:      duty_step      <= cfg_data[DUTY_W-1:0];
        REG_DUTY_MIN:       duty_min       <= cfg_data[DUTY_W-1:0];
        REG_DUTY_MAX:       duty_max       <= cfg_data[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/mppo_checker.sv]
`default_nettype none
module mppo_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire mppo_pkg::mppo_out_t out_data
);
  import mppo_pkg::*;

  // A stalled result word stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // An accepted word leaves the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after acceptance");

  // A result only appears at the end of a tick's work.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // With no word offered, an idle block stays idle.
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    in_ready && !in_valid |=> in_ready)
    else $error("block left idle without a word");

endmodule

bind mppt_perturb_observe_unit mppo_checker u_mppo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
